FILE: hdl/accel_tilt_angles_top_macros.svh
// ------------------------------------------------------------------------
// accel tilt angles assertion macros
// Concurrent check helpers clocked on clk and disabled while rst_n is low.
// ------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLES_TOP_MACROS_SVH
`define ACCEL_TILT_ANGLES_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent in this cycle implies consequent in the same cycle
`define ATILT_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tilt angle check failed");

// antecedent implies consequent after the delay given by dly
`define ATILT_ASSERT_AFTER(label, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("tilt angle timing check failed");

`else

`define ATILT_ASSERT_IMPLY(label, ante, cons)
`define ATILT_ASSERT_AFTER(label, ante, dly, cons)

`endif

`endif

FILE: hdl/atilt_pkg.sv
// ------------------------------------------------------------------------
// atilt_pkg
// Shared widths, the arctangent table and the stage-to-stage beat types
// of the accelerometer tilt angle pipeline.
// ------------------------------------------------------------------------
package atilt_pkg;

    // field widths
    localparam int ACC_W       = 16;
    localparam int ANGLE_W     = 15;
    localparam int SQ_W        = 32;
    localparam int FRAC_BITS   = 8;
    localparam int RAD_W       = 48;
    localparam int ROOT_W      = 24;
    localparam int REM_W       = 27;
    localparam int XY_W        = 28;
    localparam int Z_W         = 24;
    localparam int ATAN_W      = 21;
    localparam int TABLE_LEN   = 24;

    // defaults and limits
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_LIMIT      = 9000;
    localparam int ROUND_HALF       = 128;

    // atan(2^-i) in degrees * 100 * 256, rounded
    localparam logic [ATAN_W-1:0] ATAN_Q8 [TABLE_LEN] = '{
        21'd1152000, 21'd680065, 21'd359328, 21'd182400,
        21'd91554,   21'd45822,  21'd22916,  21'd11459,
        21'd5730,    21'd2865,   21'd1432,   21'd716,
        21'd358,     21'd179,    21'd90,     21'd45,
        21'd22,      21'd11,     21'd6,      21'd3,
        21'd1,       21'd1,      21'd0,      21'd0
    };

    // beat sideband carried alongside the square root
    typedef struct packed {
        logic                    valid;
        logic                    zero;
        logic signed [ACC_W-1:0] n;
    } atilt_side_t;

    // beat leaving the cordic
    typedef struct packed {
        logic                  valid;
        logic                  zero;
        logic signed [Z_W-1:0] z;
    } atilt_ang_t;

endpackage

FILE: hdl/atilt_isqrt.sv
// ------------------------------------------------------------------------
// atilt_isqrt
// Pipelined integer square root of sq * 2^16, one root bit per stage,
// giving the magnitude with eight fraction bits. Sideband rides along.
// ------------------------------------------------------------------------
module atilt_isqrt
    import atilt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  atilt_side_t        side_in,
    input  logic [SQ_W-1:0]    sq,
    output atilt_side_t        side_out,
    output logic [ROOT_W-1:0]  root
);

    localparam int STEPS = ROOT_W;

    logic [RAD_W-1:0]  rad_reg  [STEPS];
    logic [REM_W-1:0]  rem_reg  [STEPS];
    logic [ROOT_W-1:0] root_reg [STEPS];
    atilt_side_t       side_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_sq
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        atilt_side_t       side_stage;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              take;
        logic [RAD_W-1:0]  rad_next;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        // stage inputs
        if (k == 0)
        begin : g_first
            assign rad_in     = {sq, {(RAD_W-SQ_W){1'b0}}};
            assign rem_in     = '0;
            assign root_in    = '0;
            assign side_stage = side_in;
        end
        else
        begin : g_next
            assign rad_in     = rad_reg[k-1];
            assign rem_in     = rem_reg[k-1];
            assign root_in    = root_reg[k-1];
            assign side_stage = side_reg[k-1];
        end

        // bring down the next radicand pair and try the next root bit
        assign rem_sh    = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial     = {{(REM_W-ROOT_W-2){1'b0}}, root_in, 2'b01};
        assign take      = (rem_sh >= trial);
        assign rem_next  = take ? (rem_sh - trial) : rem_sh;
        assign root_next = {root_in[ROOT_W-2:0], take};
        assign rad_next  = {rad_in[RAD_W-3:0], 2'b00};

        // valid bit and sideband
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[k] <= '0;
            end
            else
            begin
                side_reg[k] <= side_stage;
            end
        end

        // payload
        always_ff @(posedge clk)
        begin
            rad_reg[k]  <= rad_next;
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
        end
    end

    assign side_out = side_reg[STEPS-1];
    assign root     = root_reg[STEPS-1];

endmodule

FILE: hdl/atilt_cordic.sv
// ------------------------------------------------------------------------
// atilt_cordic
// Pipelined vectoring cordic, one micro-rotation per stage, driving y to
// zero and accumulating the angle in hundredths of a degree (q8).
// ------------------------------------------------------------------------
module atilt_cordic
    import atilt_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  atilt_side_t        side_in,
    input  logic [ROOT_W-1:0]  mag,
    output atilt_ang_t         ang_out
);

    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    logic signed [XY_W-1:0] x_reg [STEPS];
    logic signed [XY_W-1:0] y_reg [STEPS];
    atilt_ang_t             a_reg [STEPS];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_rot
        logic signed [XY_W-1:0] x_in;
        logic signed [XY_W-1:0] y_in;
        atilt_ang_t             a_in;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic signed [Z_W-1:0]  step_ang;
        logic signed [XY_W-1:0] x_next;
        logic signed [XY_W-1:0] y_next;
        logic signed [Z_W-1:0]  z_next;

        // stage inputs
        if (i == 0)
        begin : g_first
            assign x_in     = {{(XY_W-ROOT_W){1'b0}}, mag};
            assign y_in     = {{(XY_W-ACC_W-FRAC_BITS){side_in.n[ACC_W-1]}},
                               side_in.n, {FRAC_BITS{1'b0}}};
            assign a_in.valid = side_in.valid;
            assign a_in.zero  = side_in.zero;
            assign a_in.z     = '0;
        end
        else
        begin : g_next
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign a_in = a_reg[i-1];
        end

        // rotate toward y = 0
        assign dx       = y_in >>> i;
        assign dy       = x_in >>> i;
        assign step_ang = $signed({{(Z_W-ATAN_W){1'b0}}, ATAN_Q8[i]});

        always_comb
        begin
            if (!y_in[XY_W-1])
            begin
                x_next = x_in + dx;
                y_next = y_in - dy;
                z_next = a_in.z + step_ang;
            end
            else
            begin
                x_next = x_in - dx;
                y_next = y_in + dy;
                z_next = a_in.z - step_ang;
            end
        end

        // valid bit, zero flag and angle
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_reg[i] <= '0;
            end
            else
            begin
                a_reg[i].valid <= a_in.valid;
                a_reg[i].zero  <= a_in.zero;
                a_reg[i].z     <= z_next;
            end
        end

        // payload
        always_ff @(posedge clk)
        begin
            x_reg[i] <= x_next;
            y_reg[i] <= y_next;
        end
    end

    assign ang_out = a_reg[STEPS-1];

endmodule

FILE: hdl/accel_tilt_angles_top.sv
// ------------------------------------------------------------------------
// accel_tilt_angles_top
// Roll and pitch in hundredths of a degree from one raw accelerometer sample.
// Stages from start to done: a squares stage, a sums stage, 24 square root
// stages, one stage per cordic step (capped at the table length) and one
// rounding stage. One sample per cycle, busy stays low.
// Reset clears the valid bits of every stage, dropping any sample in flight.
// ------------------------------------------------------------------------
`include "accel_tilt_angles_top_macros.svh"

module accel_tilt_angles_top
    import atilt_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [ACC_W-1:0]   accel_x,
    input  logic signed [ACC_W-1:0]   accel_y,
    input  logic signed [ACC_W-1:0]   accel_z,
    output logic                      done,
    output logic signed [ANGLE_W-1:0] roll_angle,
    output logic signed [ANGLE_W-1:0] pitch_angle
);

    localparam int RUN_STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int LATENCY   = ROOT_W + RUN_STEPS + 3;
    localparam int Q_W       = Z_W + 1 - FRAC_BITS;

    localparam logic signed [Q_W-1:0]     Q_MAX   = Q_W'(ANGLE_LIMIT);
    localparam logic signed [Q_W-1:0]     Q_MIN   = -Q_W'(ANGLE_LIMIT);
    localparam logic signed [ANGLE_W-1:0] ANG_MAX = ANGLE_W'(ANGLE_LIMIT);
    localparam logic signed [ANGLE_W-1:0] ANG_MIN = -ANGLE_W'(ANGLE_LIMIT);

    // the pipeline takes a beat every cycle
    assign busy = 1'b0;

    // stage 1: squares
    logic signed [SQ_W-1:0] xx_prod;
    logic signed [SQ_W-1:0] yy_prod;
    logic signed [SQ_W-1:0] zz_prod;
    logic [SQ_W-1:0]        xsq_reg;
    logic [SQ_W-1:0]        ysq_reg;
    logic [SQ_W-1:0]        zsq_reg;
    logic signed [ACC_W-1:0] ax_reg;
    logic signed [ACC_W-1:0] ay_reg;
    logic                   v1_reg;

    assign xx_prod = SQ_W'(accel_x) * SQ_W'(accel_x);
    assign yy_prod = SQ_W'(accel_y) * SQ_W'(accel_y);
    assign zz_prod = SQ_W'(accel_z) * SQ_W'(accel_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        xsq_reg <= $unsigned(xx_prod);
        ysq_reg <= $unsigned(yy_prod);
        zsq_reg <= $unsigned(zz_prod);
        ax_reg  <= accel_x;
        ay_reg  <= accel_y;
    end

    // stage 2: sums of squares and zero detect
    logic [SQ_W-1:0] sq_roll_next;
    logic [SQ_W-1:0] sq_pitch_next;
    logic [SQ_W-1:0] sq_roll_reg;
    logic [SQ_W-1:0] sq_pitch_reg;
    atilt_side_t     roll_side_reg;
    atilt_side_t     pitch_side_reg;

    assign sq_roll_next  = xsq_reg + zsq_reg;
    assign sq_pitch_next = ysq_reg + zsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_side_reg  <= '0;
            pitch_side_reg <= '0;
        end
        else
        begin
            roll_side_reg.valid  <= v1_reg;
            pitch_side_reg.valid <= v1_reg;
            roll_side_reg.n      <= ay_reg;
            pitch_side_reg.n     <= ax_reg;
            roll_side_reg.zero   <= (sq_roll_next == '0) && (ay_reg == '0);
            pitch_side_reg.zero  <= (sq_pitch_next == '0) && (ax_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        sq_roll_reg  <= sq_roll_next;
        sq_pitch_reg <= sq_pitch_next;
    end

    // magnitudes
    atilt_side_t       roll_side_sq;
    atilt_side_t       pitch_side_sq;
    logic [ROOT_W-1:0] roll_mag;
    logic [ROOT_W-1:0] pitch_mag;

    atilt_isqrt u_isqrt_roll (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (roll_side_reg),
        .sq       (sq_roll_reg),
        .side_out (roll_side_sq),
        .root     (roll_mag)
    );

    atilt_isqrt u_isqrt_pitch (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (pitch_side_reg),
        .sq       (sq_pitch_reg),
        .side_out (pitch_side_sq),
        .root     (pitch_mag)
    );

    // arctangents
    atilt_ang_t roll_ang;
    atilt_ang_t pitch_ang;

    atilt_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic_roll (
        .clk     (clk),
        .rst_n   (rst_n),
        .side_in (roll_side_sq),
        .mag     (roll_mag),
        .ang_out (roll_ang)
    );

    atilt_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic_pitch (
        .clk     (clk),
        .rst_n   (rst_n),
        .side_in (pitch_side_sq),
        .mag     (pitch_mag),
        .ang_out (pitch_ang)
    );

    // round to the nearest hundredth, ties upward, then clamp; a zero sample gives zero and pitch is negated
    logic signed [Z_W:0]        roll_rnd;
    logic signed [Z_W:0]        pitch_rnd;
    logic signed [Q_W-1:0]      roll_q;
    logic signed [Q_W-1:0]      pitch_q;
    logic signed [ANGLE_W-1:0]  roll_next;
    logic signed [ANGLE_W-1:0]  pitch_next;
    logic signed [ANGLE_W-1:0]  pitch_pos;
    logic signed [ANGLE_W-1:0]  roll_angle_reg;
    logic signed [ANGLE_W-1:0]  pitch_angle_reg;
    logic                       done_reg;

    assign roll_rnd  = {roll_ang.z[Z_W-1], roll_ang.z} + (Z_W+1)'(ROUND_HALF);
    assign pitch_rnd = {pitch_ang.z[Z_W-1], pitch_ang.z} + (Z_W+1)'(ROUND_HALF);
    assign roll_q    = roll_rnd[Z_W:FRAC_BITS];
    assign pitch_q   = pitch_rnd[Z_W:FRAC_BITS];

    always_comb
    begin
        priority if (roll_ang.zero)
        begin
            roll_next = '0;
        end
        else if (roll_q > Q_MAX)
        begin
            roll_next = ANG_MAX;
        end
        else if (roll_q < Q_MIN)
        begin
            roll_next = ANG_MIN;
        end
        else
        begin
            roll_next = roll_q[ANGLE_W-1:0];
        end

        priority if (pitch_ang.zero)
        begin
            pitch_pos = '0;
        end
        else if (pitch_q > Q_MAX)
        begin
            pitch_pos = ANG_MAX;
        end
        else if (pitch_q < Q_MIN)
        begin
            pitch_pos = ANG_MIN;
        end
        else
        begin
            pitch_pos = pitch_q[ANGLE_W-1:0];
        end
        pitch_next = -pitch_pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= roll_ang.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        roll_angle_reg  <= roll_next;
        pitch_angle_reg <= pitch_next;
    end

    assign done        = done_reg;
    assign roll_angle  = roll_angle_reg;
    assign pitch_angle = pitch_angle_reg;

    // checks
    logic still_beat;
    logic angles_in_range;

    assign still_beat      = start && !busy && (accel_x == '0) && (accel_y == '0)
                             && (accel_z == '0);
    assign angles_in_range = (roll_angle <= ANG_MAX) && (roll_angle >= ANG_MIN)
                             && (pitch_angle <= ANG_MAX) && (pitch_angle >= ANG_MIN);

    `ATILT_ASSERT_AFTER(a_fixed_latency, start && !busy, LATENCY, done)
    `ATILT_ASSERT_IMPLY(a_lanes_aligned, roll_ang.valid, pitch_ang.valid)
    `ATILT_ASSERT_AFTER(a_still_sample, still_beat, LATENCY, (roll_angle == '0) && (pitch_angle == '0))
    `ATILT_ASSERT_IMPLY(a_angle_range, done, angles_in_range)

endmodule

FILE: test/testbench.sv
// ------------------------------------------------------------------------
// accel tilt angles testbench
// Drives raw three-axis samples into the tilt angle pipeline in random
// bursts, predicts roll and pitch with an independent fixed-point cordic
// and checks every result beat in order against the prediction.
// ------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import atilt_pkg::*;

    localparam int N_STEPS     = 16;
    localparam int PIPE_DEPTH  = 27 + N_STEPS;
    localparam int RANDOM_N    = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;
    localparam int CORNER_N    = 22;
    localparam int TABLE_DEPTH = 24;

    // atan(2^-i) in hundredths of a degree with 8 fraction bits
    localparam longint ARCTAN_Q8 [TABLE_DEPTH] = '{
        1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
        5730, 2865, 1432, 716, 358, 179, 90, 45,
        22, 11, 6, 3, 1, 1, 0, 0
    };

    typedef logic signed [ACC_W-1:0]   axis_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;

    typedef struct {
        axis_t  ax;
        axis_t  ay;
        axis_t  az;
        angle_t roll;
        angle_t pitch;
    } tilt_beat_t;

    // expected angles and in-order comparison
    class tilt_scoreboard;
        tilt_beat_t expected_angles [$];
        int         mismatches;

        function new();
            mismatches = 0;
        endfunction

        // integer square root, bit by bit
        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned rem;
            longint unsigned root;
            longint unsigned one;
            rem  = v;
            root = 0;
            one  = 64'h1 << 62;
            while (one > rem)
                one = one >> 2;
            while (one != 0)
            begin
                if (rem >= root + one)
                begin
                    rem  = rem - (root + one);
                    root = (root >> 1) + one;
                end
                else
                begin
                    root = root >> 1;
                end
                one = one >> 2;
            end
            return root;
        endfunction

        // atan2(n, hypot(p, q)) in hundredths of a degree, rounded and clamped
        function longint tilt_centideg(longint n, longint p, longint q);
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            longint r;
            x = longint'(int_sqrt(longint'(p * p + q * q) << 16));
            y = n * 256;
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            for (int i = 0; i < N_STEPS && i < TABLE_DEPTH; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ARCTAN_Q8[i];
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ARCTAN_Q8[i];
                end
            end
            r = (z + 128) >>> 8;
            if (r > 9000)
                r = 9000;
            if (r < -9000)
                r = -9000;
            return r;
        endfunction

        // accepted sample: predict both angles
        function void note_sample(axis_t ax, axis_t ay, axis_t az);
            tilt_beat_t beat;
            longint     roll_v;
            longint     pitch_v;
            roll_v     = tilt_centideg(longint'(ay), longint'(ax), longint'(az));
            pitch_v    = -tilt_centideg(longint'(ax), longint'(ay), longint'(az));
            beat.ax    = ax;
            beat.ay    = ay;
            beat.az    = az;
            beat.roll  = angle_t'(roll_v[ANGLE_W-1:0]);
            beat.pitch = angle_t'(pitch_v[ANGLE_W-1:0]);
            expected_angles.push_back(beat);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%s", msg);
        endfunction

        // result beat against the oldest prediction
        function void check_angles(angle_t roll, angle_t pitch);
            tilt_beat_t beat;
            if (expected_angles.size() == 0)
            begin
                report($sformatf("unexpected result beat: roll %0d pitch %0d",
                                 roll, pitch));
                return;
            end
            beat = expected_angles.pop_front();
            if (roll !== beat.roll)
                report($sformatf("roll mismatch for x %0d y %0d z %0d: exp %0d got %0d",
                                 beat.ax, beat.ay, beat.az, beat.roll, roll));
            if (pitch !== beat.pitch)
                report($sformatf("pitch mismatch for x %0d y %0d z %0d: exp %0d got %0d",
                                 beat.ax, beat.ay, beat.az, beat.pitch, pitch));
        endfunction
    endclass

    logic   clk;
    logic   rst_n   = 1'b0;
    logic   start   = 1'b0;
    axis_t  accel_x = '0;
    axis_t  accel_y = '0;
    axis_t  accel_z = '0;
    logic   busy;
    logic   done;
    angle_t roll_angle;
    angle_t pitch_angle;

    tilt_scoreboard sb = new();
    int             cycle_count = 0;
    int             burst_left  = 0;

    // extremes, level poses and both special cases on each angle
    int corner [CORNER_N][3] = '{
        '{0, 0, 0},            '{0, 0, 16384},        '{0, 0, -16384},
        '{16384, 0, 0},        '{-16384, 0, 0},       '{0, 16384, 0},
        '{0, -16384, 0},       '{32767, 0, 0},        '{-32768, 0, 0},
        '{0, 32767, 0},        '{0, -32768, 0},       '{0, 0, -32768},
        '{32767, 32767, 32767}, '{-32768, -32768, -32768},
        '{32767, -32768, 0},   '{-32768, 32767, 32767},
        '{1, 1, 1},            '{-1, -1, -1},         '{1, 0, 0},
        '{0, -1, 0},           '{11585, 11585, 0},    '{-1, 0, 32767}
    };

    accel_tilt_angles_top #(
        .CORDIC_STEPS (N_STEPS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .accel_x     (accel_x),
        .accel_y     (accel_y),
        .accel_z     (accel_z),
        .done        (done),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_angles(roll_angle, pitch_angle);
    end

    // run timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // one sample beat, held until accepted
    task automatic send_sample(input axis_t ax, input axis_t ay, input axis_t az);
        start   <= 1'b1;
        accel_x <= ax;
        accel_y <= ay;
        accel_z <= az;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_sample(ax, ay, az);
    endtask

    // bursts of random length with random gaps
    task automatic pace_sender();
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        if ($urandom_range(0, 3) != 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(0, 8);
    endtask

    // one axis value of a chosen flavor
    function automatic axis_t pick_axis(int flavor);
        case (flavor)
            0:       return axis_t'($urandom);
            1:       return axis_t'(int'($urandom_range(0, 34000)) - 17000);
            2:       return axis_t'(int'($urandom_range(0, 16)) - 8);
            3:       return ($urandom_range(0, 1) == 0) ? axis_t'(0) : axis_t'($urandom);
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       return axis_t'(-32768);
                    1:       return axis_t'(-32767);
                    2:       return axis_t'(-1);
                    3:       return axis_t'(0);
                    4:       return axis_t'(1);
                    default: return axis_t'(32767);
                endcase
            end
        endcase
    endfunction

    // stimulus and end of run
    initial
    begin
        int flavor;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        foreach (corner[k])
        begin
            send_sample(axis_t'(corner[k][0]), axis_t'(corner[k][1]),
                        axis_t'(corner[k][2]));
            pace_sender();
        end

        // random samples
        repeat (RANDOM_N)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: flavor = 0;
                4, 5, 6:    flavor = 1;
                7:          flavor = 2;
                8:          flavor = 3;
                default:    flavor = 4;
            endcase
            send_sample(pick_axis(flavor), pick_axis(flavor), pick_axis(flavor));
            pace_sender();
        end
        start <= 1'b0;

        // drain the pipeline
        while (sb.expected_angles.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 8) @(posedge clk);

        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
